// ----- src/random_sample_without_replacement_macros.svh -----
// Assertion macros shared by the sampler RTL.
`ifndef RANDOM_SAMPLE_WITHOUT_REPLACEMENT_MACROS_SVH
`define RANDOM_SAMPLE_WITHOUT_REPLACEMENT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define RSWR_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked at every rising clock edge outside reset
`define RSWR_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error(msg);

`endif

// ----- src/rswr_pkg.sv -----
// Shared types and constants of the random sampler.
package rswr_pkg;

    // Field and register widths
    localparam int WORD_W    = 31;
    localparam int ID_W      = 32;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int TAG_W     = 4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ID        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RESTART   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_POOL  = 2'd1,
        CFG_COUNT = 2'd2
    } cfg_idx_t;

    // Item modes
    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_DRAW    = 1'b1;

    // Request to the serial modulo unit
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

    // Response from the serial modulo unit
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage

// ----- src/rswr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rswr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/rswr_mod.sv -----
// Bit-serial restoring modulo unit: one dividend bit per cycle.
module rswr_mod (
    input  logic               clk,
    input  logic               rst_n,
    input  rswr_pkg::mod_req_t req,
    output rswr_pkg::mod_rsp_t rsp
);

    import rswr_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] step_reg, step_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]   dvd_reg, dvd_next;
    logic [CNT_W-1:0]    div_reg, div_next;
    logic [CNT_W:0]      trial;

    // Shift in the next dividend bit and subtract the divisor when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        trial     = {rem_reg, dvd_reg[WORD_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = CNT_BITS'(WORD_W - 1);
            rem_next  = '0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dvd_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            div_reg  <= div_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- src/random_sample_without_replacement.sv -----
// Top level of the partial Fisher-Yates random sampler.
// Draws distinct ids from base_value .. base_value + pool - 1, where pool is
// min(pool_size, POOL_SIZE). The swap table sits in one RAM whose entries carry
// an epoch tag; an entry whose tag differs from the current epoch reads as its
// own index, so a restart clears the round by bumping the epoch. A draw runs
// the bit-serial modulo of the random word by the remaining pool, then two RAM
// reads, one write and the result beat. Restart, exhausted and overflow items
// skip these steps, except that every 15th restart wraps the 4-bit epoch and
// first sweeps every RAM entry to tag zero. After reset the same sweep runs
// before the first item is taken; configuration writes are taken at any time.
// One item is in work at a time; a finished result waits in an output register
// while the next item is taken.
`include "random_sample_without_replacement_macros.svh"

module random_sample_without_replacement #(
    parameter int POOL_SIZE = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_write,
    input  logic [rswr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rswr_pkg::ID_W-1:0]            cfg_data,
    // Item channel
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 mode,
    input  logic [rswr_pkg::WORD_W-1:0]          random_word,
    // Result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [rswr_pkg::ID_W-1:0]     id_value,
    output logic [1:0]                           status,
    output logic                                 last
);

    import rswr_pkg::*;

    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int WIDE_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int RAM_W  = TAG_W + IDX_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD_R,
        S_RD_POS,
        S_WR,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;

    // Configuration registers
    logic [ID_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]  pool_reg, pool_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // Round state
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  round_limit_reg, round_limit_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [TAG_W-1:0]  epoch_reg, epoch_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              clr_ret_reg, clr_ret_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  picked_reg, picked_next;

    // Staged and presented result
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    status_t           pend_status_reg, pend_status_next;
    logic              pend_last_reg, pend_last_next;
    logic              res_valid_reg, res_valid_next;
    logic [ID_W-1:0]   id_reg, id_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    // Derived values
    logic              accept;
    logic [CNT_W-1:0]  eff_pool;
    logic [CNT_W-1:0]  round_lim;
    logic signed [ID_W:0] span_top;
    logic              range_ovf;
    logic [WIDE_W-1:0] r_wide;
    logic [WIDE_W-1:0] pos_wide;
    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  pos_addr;
    logic [IDX_W-1:0]  fallback_addr;
    logic [IDX_W-1:0]  table_val;

    // RAM and modulo unit connections
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [RAM_W-1:0]  ram_rdata;
    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    rswr_ram #(
        .WIDTH (RAM_W),
        .DEPTH (POOL_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rswr_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Effective pool, clamped limit and id range check
    always_comb
    begin
        if (32'(pool_reg) < 32'(POOL_SIZE))
        begin
            eff_pool = pool_reg;
        end
        else
        begin
            eff_pool = CNT_W'(POOL_SIZE);
        end
        round_lim = (round_limit_reg < eff_pool) ? round_limit_reg : eff_pool;
        span_top  = $signed({base_reg[ID_W-1], base_reg})
                  + $signed({{(ID_W + 1 - CNT_W){1'b0}}, eff_pool})
                  - $signed((ID_W + 1)'(1));
        range_ovf = (eff_pool != '0) && (span_top > $signed({1'b0, 1'b0, {(ID_W-1){1'b1}}}));
    end

    // Table addresses and identity fallback for entries of older epochs
    assign r_wide        = WIDE_W'(r_reg);
    assign pos_wide      = WIDE_W'(pos_reg);
    assign r_addr        = r_wide[IDX_W-1:0];
    assign pos_addr      = pos_wide[IDX_W-1:0];
    assign fallback_addr = (state_reg == S_RD_POS) ? r_addr : pos_addr;
    assign table_val     = (ram_rdata[RAM_W-1:IDX_W] == epoch_reg) ? ram_rdata[IDX_W-1:0]
                                                                    : fallback_addr;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        base_next        = base_reg;
        pool_next        = pool_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        round_limit_next = round_limit_reg;
        limit_next       = limit_reg;
        epoch_next       = epoch_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_ret_next     = clr_ret_reg;
        r_next           = r_reg;
        picked_next      = picked_reg;
        pend_id_next     = pend_id_reg;
        pend_status_next = pend_status_reg;
        pend_last_next   = pend_last_reg;
        res_valid_next   = res_valid_reg;
        id_next          = id_reg;
        status_next      = status_reg;
        last_next        = last_reg;

        mod_req.start    = 1'b0;
        mod_req.dividend = random_word;
        mod_req.divisor  = eff_pool - pos_reg;

        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {epoch_reg, table_val};
        ram_raddr = r_addr;

        // Result beat taken downstream
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BASE:  base_next  = cfg_data;
                CFG_POOL:  pool_next  = cfg_data[CNT_W-1:0];
                CFG_COUNT: count_next = cfg_data[CNT_W-1:0];
                default:   ;
            endcase
        end

        unique case (state_reg)
            // Sweep the table to tag zero, one entry per cycle
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == IDX_W'(POOL_SIZE - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_ret_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end

            // Take an item and sort out the short cases
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_id_next   = '0;
                    pend_last_next = 1'b0;
                    if (range_ovf)
                    begin
                        pend_status_next = ST_OVERFLOW;
                        state_next       = S_FINISH;
                    end
                    else if (mode == MODE_RESTART)
                    begin
                        pos_next         = '0;
                        round_limit_next = (count_reg < eff_pool) ? count_reg : eff_pool;
                        pend_status_next = ST_RESTART;
                        if (epoch_reg == '1)
                        begin
                            epoch_next   = TAG_W'(1);
                            clr_ret_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + TAG_W'(1);
                            state_next = S_FINISH;
                        end
                    end
                    else if (pos_reg >= round_lim)
                    begin
                        pend_status_next = ST_EXHAUSTED;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        limit_next    = round_lim;
                        mod_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end

            // Wait for the remainder, then form the swap index
            S_DIV:
            begin
                if (mod_rsp.done)
                begin
                    r_next     = pos_reg + mod_rsp.remainder;
                    state_next = S_RD_R;
                end
            end

            // Read entry r
            S_RD_R:
            begin
                ram_raddr  = r_addr;
                state_next = S_RD_POS;
            end

            // Capture entry r, read entry at the position
            S_RD_POS:
            begin
                picked_next = table_val;
                ram_raddr   = pos_addr;
                state_next  = S_WR;
            end

            // Move the position entry into slot r and stage the id
            S_WR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = r_addr;
                ram_wdata        = {epoch_reg, table_val};
                pend_id_next     = base_reg + ID_W'(picked_reg);
                pend_status_next = ST_ID;
                pend_last_next   = ((pos_reg + CNT_W'(1)) == limit_reg);
                pos_next         = pos_reg + CNT_W'(1);
                state_next       = S_FINISH;
            end

            // Load the output register once it is free
            S_FINISH:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next = 1'b1;
                    id_next        = pend_id_reg;
                    status_next    = pend_status_reg;
                    last_next      = pend_last_reg;
                    clr_ret_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            base_reg        <= '0;
            pool_reg        <= '0;
            count_reg       <= '0;
            pos_reg         <= '0;
            round_limit_reg <= '0;
            limit_reg       <= '0;
            epoch_reg       <= TAG_W'(1);
            clr_cnt_reg     <= '0;
            clr_ret_reg     <= 1'b0;
            r_reg           <= '0;
            picked_reg      <= '0;
            pend_id_reg     <= '0;
            pend_status_reg <= ST_ID;
            pend_last_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
            id_reg          <= '0;
            status_reg      <= ST_ID;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            base_reg        <= base_next;
            pool_reg        <= pool_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            round_limit_reg <= round_limit_next;
            limit_reg       <= limit_next;
            epoch_reg       <= epoch_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_ret_reg     <= clr_ret_next;
            r_reg           <= r_next;
            picked_reg      <= picked_next;
            pend_id_reg     <= pend_id_next;
            pend_status_reg <= pend_status_next;
            pend_last_reg   <= pend_last_next;
            res_valid_reg   <= res_valid_next;
            id_reg          <= id_next;
            status_reg      <= status_next;
            last_reg        <= last_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign id_value     = $signed(id_reg);
    assign status       = status_reg;
    assign last         = last_reg;

    // Checks
    `RSWR_ASSERT_IMPLY(a_done_in_div, clk, rst_n, mod_rsp.done, state_reg == S_DIV, "modulo done outside divide state")
    `RSWR_ASSERT_IMPLY(a_rem_range, clk, rst_n, mod_rsp.done, mod_rsp.remainder < (eff_pool - pos_reg), "remainder not below remaining pool")
    `RSWR_ASSERT_IMPLY(a_swap_in_pool, clk, rst_n, ram_we && (state_reg == S_WR), r_reg < eff_pool, "swap write outside pool")
    `RSWR_ASSERT_IMPLY(a_no_id_clean, clk, rst_n, result_valid && (status != ST_ID), (id_value == '0) && !last, "non-id result carries id or last")
    `RSWR_ASSERT_ALWAYS(a_epoch_live, clk, rst_n, epoch_reg != '0, "epoch equals cleared tag")

endmodule

// ----- tb/random_sample_without_replacement_test.sv -----
// Self-checking testbench for the partial Fisher-Yates random sampler.
module random_sample_without_replacement_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rswr_pkg::*;

    localparam int POOL_DEPTH  = 1024;
    localparam int TOTAL_ITEMS = 1525;
    localparam int QUIET_FROM  = 1350;
    localparam int CYCLE_LIMIT = 1000000;

    // One expected answer of the sampler
    typedef struct packed {
        logic [ID_W-1:0] id;
        status_t         st;
        logic            last_flag;
    } sample_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ID_W-1:0]      cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic                 mode = MODE_RESTART;
    logic [WORD_W-1:0]    random_word = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic signed [ID_W-1:0] id_value;
    logic [1:0]           status;
    logic                 last_id;

    // Shadow of the configuration registers
    logic [ID_W-1:0]  base_q = '0;
    logic [CNT_W-1:0] pool_q = '0;
    logic [CNT_W-1:0] count_q = '0;

    // Shadow of the shuffle state
    bit [POOL_DEPTH-1:0]          written = '0;
    logic [$clog2(POOL_DEPTH)-1:0] swap_tbl [POOL_DEPTH];
    int unsigned                  draw_pos = 0;
    int unsigned                  round_lim = 0;

    sample_result_t expected_results [$];
    bit             idle_on = 1'b1;
    int             items_sent = 0;
    int             mismatches = 0;
    int             ids_seen = 0;
    int             restarts_seen = 0;
    int             exhausted_seen = 0;
    int             overflow_seen = 0;

    random_sample_without_replacement #(
        .POOL_SIZE(POOL_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .mode(mode),
        .random_word(random_word),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .id_value(id_value),
        .status(status),
        .last(last_id)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shuffle predictor: answer of one item, state updated in place
    function automatic sample_result_t predict_sample(input logic item_mode,
                                                      input logic [WORD_W-1:0] word);
        sample_result_t res;
        int unsigned pool_eff, lim, r, picked, held;
        longint top_id;
        res = '{id: '0, st: ST_ID, last_flag: 1'b0};
        pool_eff = (pool_q > POOL_DEPTH) ? POOL_DEPTH : pool_q;
        top_id = longint'($signed(base_q)) + longint'(pool_eff) - 1;
        if (pool_eff != 0 && top_id > 64'sd2147483647)
        begin
            res.st = ST_OVERFLOW;
            return res;
        end
        if (item_mode == MODE_RESTART)
        begin
            written = '0;
            draw_pos = 0;
            round_lim = (count_q < pool_eff) ? count_q : pool_eff;
            res.st = ST_RESTART;
            return res;
        end
        lim = (round_lim < pool_eff) ? round_lim : pool_eff;
        if (draw_pos >= lim)
        begin
            res.st = ST_EXHAUSTED;
            return res;
        end
        r = draw_pos + int'(word) % (pool_eff - draw_pos);
        picked = written[r] ? swap_tbl[r] : r;
        held = written[draw_pos] ? swap_tbl[draw_pos] : draw_pos;
        swap_tbl[r] = held;
        written[r] = 1'b1;
        draw_pos++;
        res.id = base_q + picked;
        res.last_flag = (draw_pos == lim);
        return res;
    endfunction

    // Random word, biased toward the extremes
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return WORD_W'($urandom());
        endcase
    endfunction

    // Drive one item beat, predict its answer once accepted
    task automatic send_item(input logic item_mode, input logic [WORD_W-1:0] word);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode <= item_mode;
        random_word <= word;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        expected_results = {expected_results, predict_sample(item_mode, word)};
        items_sent++;
    endtask

    // Drop valid and let every outstanding answer arrive
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers on an idle block
    task automatic set_config(input logic [ID_W-1:0] base, input logic [CNT_W-1:0] pool,
                              input logic [CNT_W-1:0] cnt);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_data <= base;
        @(posedge clk);
        base_q = base;
        cfg_index <= CFG_POOL;
        cfg_data <= ID_W'(pool);
        @(posedge clk);
        pool_q = pool;
        cfg_index <= CFG_COUNT;
        cfg_data <= ID_W'(cnt);
        @(posedge clk);
        count_q = cnt;
        cfg_write <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [ID_W-1:0] want,
                                        input logic [ID_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result checker: every accepted result beat against the oldest prediction
    always @(posedge clk)
    begin
        sample_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual id %0h status %0d",
                         $time, id_value, status);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("id_value", want.id, id_value);
                check_field("status", ID_W'(want.st), ID_W'(status));
                check_field("last", ID_W'(want.last_flag), ID_W'(last_id));
                case (want.st)
                    ST_ID:        ids_seen++;
                    ST_RESTART:   restarts_seen++;
                    ST_EXHAUSTED: exhausted_seen++;
                    default:      overflow_seen++;
                endcase
            end
        end
    end

    // Result side stall bursts, with quiet stretches in between
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("random_sample_without_replacement_test failed");
        $finish;
    end

    // Registers still at reset: empty pool
    task automatic test_after_reset();
        send_item(MODE_DRAW, '1);
        send_item(MODE_RESTART, '0);
        send_item(MODE_DRAW, '0);
    endtask

    // Small pool at the most negative base, extreme words, one draw past the end
    task automatic test_field_extremes();
        set_config(32'h8000_0000, 11'd5, 11'd5);
        send_item(MODE_RESTART, '1);
        send_item(MODE_DRAW, '0);
        send_item(MODE_DRAW, '1);
        send_item(MODE_DRAW, 31'h5555_5555);
        send_item(MODE_DRAW, 31'h2AAA_AAAA);
        send_item(MODE_DRAW, 31'd1);
        send_item(MODE_DRAW, 31'd7);
    endtask

    // Top of the id range: fits with one id, overflows with two
    task automatic test_range_overflow();
        set_config(32'h7FFF_FFFF, 11'd1, 11'd1);
        send_item(MODE_RESTART, '0);
        send_item(MODE_DRAW, '1);
        set_config(32'h7FFF_FFFF, 11'd2, 11'd2);
        send_item(MODE_RESTART, '0);
        send_item(MODE_DRAW, '0);
    endtask

    // Pool and count above the store depth are clamped
    task automatic test_oversize_pool();
        set_config(32'h7FFF_FC00, 11'd2047, 11'd2047);
        send_item(MODE_RESTART, '0);
        send_item(MODE_DRAW, '1);
        send_item(MODE_DRAW, '0);
    endtask

    // Pool shrunk below the position, then grown back, in one round
    task automatic test_config_mid_round();
        set_config(-32'sd10, 11'd8, 11'd8);
        send_item(MODE_RESTART, '0);
        send_item(MODE_DRAW, pick_word());
        send_item(MODE_DRAW, pick_word());
        send_item(MODE_DRAW, pick_word());
        set_config(-32'sd10, 11'd2, 11'd8);
        send_item(MODE_DRAW, pick_word());
        set_config(32'd1000, 11'd8, 11'd8);
        send_item(MODE_DRAW, pick_word());
        send_item(MODE_DRAW, pick_word());
    endtask

    // Random configurations, each with a few rounds of restart and draws
    task automatic test_random_rounds();
        logic [ID_W-1:0]  base;
        logic [CNT_W-1:0] pool, cnt;
        int unsigned      eff, draws;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= QUIET_FROM)
                idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0: pool = 11'd0;
                1: pool = 11'd1;
                2: pool = 11'd1024;
                3: pool = CNT_W'($urandom_range(1025, 2047));
                default: pool = CNT_W'($urandom_range(2, 40));
            endcase
            eff = (pool > POOL_DEPTH) ? POOL_DEPTH : pool;
            case ($urandom_range(0, 7))
                0: cnt = 11'd0;
                1: cnt = 11'd2047;
                2: cnt = CNT_W'(eff);
                default: cnt = CNT_W'($urandom_range(1, 40));
            endcase
            // keep rounds on the full store short
            if (eff > 64 && cnt > 64)
                cnt = CNT_W'($urandom_range(1, 64));
            case ($urandom_range(0, 9))
                0: base = 32'h8000_0000;
                1: base = 32'h7FFF_FFFF;
                2: base = 32'h8000_0000 - eff + $urandom_range(0, 1);  // at the overflow edge
                3: base = $urandom();
                default: base = ID_W'($urandom_range(0, 2000)) - 32'd1000;
            endcase
            set_config(base, pool, cnt);
            repeat ($urandom_range(1, 3))
            begin
                send_item(MODE_RESTART, pick_word());
                draws = ((cnt < eff) ? cnt : eff) + $urandom_range(0, 2);
                repeat (draws)
                begin
                    // occasional restart breaks the round
                    if ($urandom_range(0, 39) == 0)
                        send_item(MODE_RESTART, pick_word());
                    else
                        send_item(MODE_DRAW, pick_word());
                    if ($urandom_range(0, 99) == 0)
                    begin
                        pool = CNT_W'($urandom_range(0, 48));
                        set_config(base, pool, cnt);
                    end
                end
            end
        end
    endtask

    // Test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_field_extremes();
        test_range_overflow();
        test_oversize_pool();
        test_config_mid_round();
        test_random_rounds();
        wait_idle();
        repeat (40) @(posedge clk);
        $display("Ran %0d items over varied pools, bases and round limits:", items_sent);
        $display("  %0d ids drawn, %0d restarts, %0d exhausted, %0d range overflows",
                 ids_seen, restarts_seen, exhausted_seen, overflow_seen);
        if (mismatches == 0)
            $display("random_sample_without_replacement_test passed");
        else
            $display("random_sample_without_replacement_test failed");
        $finish;
    end

endmodule
